// File: hdl/sorted_priority_queue_core_defines.svh
// assertion helpers for the queue rtl
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spq check failed");

// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spq check failed");

`endif

// File: hdl/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int PRI_BITS = 16;
    localparam int REC_BITS = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                        op;
        logic signed [PRI_BITS-1:0] new_priority;
        logic [REC_BITS-1:0]        new_payload;
    } t_in_item;

    typedef struct packed {
        t_status                    status;
        logic signed [PRI_BITS-1:0] removed_priority;
        logic [REC_BITS-1:0]        removed_payload;
        logic [CNT_W-1:0]           insert_position;
        logic [CNT_W-1:0]           entry_count;
        logic signed [PRI_BITS-1:0] front_priority;
        logic [REC_BITS-1:0]        front_payload;
        logic signed [PRI_BITS-1:0] tail_priority;
        logic [REC_BITS-1:0]        tail_payload;
    } t_out_item;

    typedef struct packed {
        logic signed [PRI_BITS-1:0] pri;
        logic [REC_BITS-1:0]        payload;
    } t_rec;

    // broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
        logic clear;
        t_rec item;
    } t_cell_ctrl;

    // handed from a cell to its frontward neighbour
    typedef struct packed {
        logic valid;
        logic le;
        t_rec rec;
    } t_link;

endpackage

// File: hdl/spq_cell.sv
module spq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_link     i_left,
    input  logic               i_right_valid,
    output spq_pkg::t_link     o_link,
    output logic               o_take_new
);

    logic          r_valid;
    spq_pkg::t_rec r_rec;
    logic          w_le;
    logic          w_take_left;

    // entry at or below the key stays tailward of the new record
    assign w_le        = r_valid && (r_rec.pri <= i_ctrl.item.pri);
    assign w_take_left = i_left.valid && !i_left.le;
    assign o_take_new  = i_left.le && !w_le;

    assign o_link.valid = r_valid;
    assign o_link.le    = w_le;
    assign o_link.rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.remove) begin
            if (r_valid && !i_right_valid) begin
                r_valid <= 1'b0;
            end
        end else if (i_ctrl.insert) begin
            if (w_take_left || o_take_new) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            if (w_take_left) begin
                r_rec <= i_left.rec;
            end else if (o_take_new) begin
                r_rec <= i_ctrl.item;
            end
        end
    end

endmodule

// File: hdl/sorted_priority_queue_core.sv
// a request is accepted into r_req, executed in S_EXEC and loaded into the output register from S_DONE
// a new request is not taken until the last one has been reported, set by the execute/report sequencer
// execute cycle: on insert all cells compare against the key and shift in one step
// reset (synchronous, active low) clears the count, the cell valid bits, the output
// valid and the sequencer; stored records are not cleared
`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spq_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spq_pkg::t_out_item o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state                        r_state;
    spq_pkg::t_in_item             r_req;
    logic [spq_pkg::CNT_W-1:0]     r_count;
    spq_pkg::t_status              r_status;
    spq_pkg::t_rec                 r_removed;
    logic [spq_pkg::CNT_W-1:0]     r_pos;
    spq_pkg::t_out_item            r_out;
    logic                          r_out_valid;

    spq_pkg::t_cell_ctrl           w_ctrl;
    spq_pkg::t_link                w_link [spq_pkg::CAPACITY+1];
    logic [spq_pkg::CAPACITY-1:0]  w_valid;
    logic [spq_pkg::CAPACITY-1:0]  w_is_front;
    logic [spq_pkg::CAPACITY-1:0]  w_take_new;
    spq_pkg::t_rec                 w_front;
    spq_pkg::t_rec                 w_tail;
    logic [spq_pkg::CNT_W-1:0]     w_pos;
    logic                          w_full;
    logic                          w_empty;
    logic                          w_can_load;
    logic                          w_in_acc;

    assign w_full     = (r_count == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_can_load = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_DONE) && w_can_load);
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_ctrl.insert       = (r_state == S_EXEC) && (r_req.op == spq_pkg::OP_INSERT)
                                 && !w_full;
    assign w_ctrl.remove       = (r_state == S_EXEC) && (r_req.op == spq_pkg::OP_REMOVE);
    assign w_ctrl.clear        = (r_state == S_EXEC) && (r_req.op == spq_pkg::OP_CLEAR);
    assign w_ctrl.item.pri     = r_req.new_priority;
    assign w_ctrl.item.payload = r_req.new_payload;

    // tail boundary: below every key, holds nothing
    assign w_link[0].valid = 1'b0;
    assign w_link[0].le    = 1'b1;
    assign w_link[0].rec   = '0;

    for (genvar g = 0; g < spq_pkg::CAPACITY; g++) begin : g_cell
        logic w_right_valid;
        if (g == spq_pkg::CAPACITY - 1) begin : g_last
            assign w_right_valid = 1'b0;
        end else begin : g_mid
            assign w_right_valid = w_link[g+2].valid;
        end
        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_left        (w_link[g]),
            .i_right_valid (w_right_valid),
            .o_link        (w_link[g+1]),
            .o_take_new    (w_take_new[g])
        );
        assign w_valid[g]    = w_link[g+1].valid;
        assign w_is_front[g] = w_link[g+1].valid && !w_right_valid;
    end

    always_comb begin
        w_front = '0;
        w_pos   = '0;
        for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
            if (w_is_front[i]) begin
                w_front = w_front | w_link[i+1].rec;
            end
            if (w_take_new[i]) begin
                w_pos = w_pos | spq_pkg::CNT_W'(i);
            end
        end
    end

    assign w_tail = w_valid[0] ? w_link[1].rec : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc) begin
                r_req <= i_in_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_req.op)
                        spq_pkg::OP_INSERT: begin
                            r_removed <= '0;
                            if (w_full) begin
                                r_status <= spq_pkg::ST_FULL;
                                r_pos    <= '0;
                            end else begin
                                r_status <= spq_pkg::ST_OK;
                                r_pos    <= w_pos;
                                r_count  <= r_count + 1'b1;
                            end
                        end
                        spq_pkg::OP_REMOVE: begin
                            r_pos <= '0;
                            if (w_empty) begin
                                r_status  <= spq_pkg::ST_EMPTY;
                                r_removed <= '0;
                            end else begin
                                r_status  <= spq_pkg::ST_OK;
                                r_removed <= w_front;
                                r_count   <= r_count - 1'b1;
                            end
                        end
                        spq_pkg::OP_CLEAR: begin
                            if (w_empty) begin
                                r_status <= spq_pkg::ST_EMPTY;
                            end else begin
                                r_status <= spq_pkg::ST_OK;
                            end
                            r_removed <= '0;
                            r_pos     <= '0;
                            r_count   <= '0;
                        end
                        default: begin
                            r_status  <= spq_pkg::ST_OK;
                            r_removed <= '0;
                            r_pos     <= '0;
                        end
                    endcase
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_can_load) begin
                        r_out.status           <= r_status;
                        r_out.removed_priority <= r_removed.pri;
                        r_out.removed_payload  <= r_removed.payload;
                        r_out.insert_position  <= r_pos;
                        r_out.entry_count      <= r_count;
                        r_out.front_priority   <= w_front.pri;
                        r_out.front_payload    <= w_front.payload;
                        r_out.tail_priority    <= w_tail.pri;
                        r_out.tail_payload     <= w_tail.payload;
                        r_out_valid            <= 1'b1;
                        r_state                <= i_in_valid ? S_EXEC : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // valid cells form a solid run from the tail, as long as the count
    `SPQ_ASSERT_NOW(a_valid_run, 1'b1, ((w_valid & (w_valid + 1'b1)) == '0))
    `SPQ_ASSERT_NOW(a_count_match, 1'b1, ($countones(w_valid) == r_count))
    `SPQ_ASSERT_NOW(a_one_slot, w_ctrl.insert, $onehot(w_take_new))
    `SPQ_ASSERT_NEXT(a_insert_grows, w_ctrl.insert, (r_count == $past(r_count) + 1'b1))

endmodule

// File: dv/tb_top.sv
module tb_top;

    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    class sorted_queue_mirror;
        logic signed [PRI_BITS-1:0] held_pri [CAPACITY];
        logic [REC_BITS-1:0]        held_pay [CAPACITY];
        int                         held;
        t_out_item                  expected_reports [$];
        int                         mismatches;
        int                         checked;
        int                         full_seen;
        int                         empty_seen;

        function new();
            held       = 0;
            mismatches = 0;
            checked    = 0;
            full_seen  = 0;
            empty_seen = 0;
        endfunction

        function void apply_request(t_in_item req);
            t_out_item                  rpt;
            logic signed [PRI_BITS-1:0] key;
            int                         pos;
            int                         i;
            rpt        = '0;
            rpt.status = ST_OK;
            key        = req.new_priority;
            case (req.op)
                OP_INSERT: begin
                    if (held >= CAPACITY) begin
                        rpt.status = ST_FULL;
                    end else begin
                        pos = 0;
                        while (pos < held && held_pri[pos] <= key) pos++;
                        for (i = held; i > pos; i--) begin
                            held_pri[i] = held_pri[i-1];
                            held_pay[i] = held_pay[i-1];
                        end
                        held_pri[pos] = key;
                        held_pay[pos] = req.new_payload;
                        held++;
                        rpt.insert_position = CNT_W'(pos);
                    end
                end
                OP_REMOVE: begin
                    if (held == 0) begin
                        rpt.status = ST_EMPTY;
                    end else begin
                        rpt.removed_priority = held_pri[held-1];
                        rpt.removed_payload  = held_pay[held-1];
                        held--;
                    end
                end
                OP_CLEAR: begin
                    if (held == 0) rpt.status = ST_EMPTY;
                    held = 0;
                end
                default: begin
                end
            endcase
            rpt.entry_count = CNT_W'(held);
            if (held > 0) begin
                rpt.front_priority = held_pri[held-1];
                rpt.front_payload  = held_pay[held-1];
                rpt.tail_priority  = held_pri[0];
                rpt.tail_payload   = held_pay[0];
            end
            if (rpt.status == ST_FULL) full_seen++;
            if (rpt.status == ST_EMPTY) empty_seen++;
            expected_reports.push_back(rpt);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                if (mismatches < 10)
                    $display("mismatch in %s of report %0d: expected %h, got %h",
                             name, checked, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(t_out_item got);
            t_out_item want;
            if (expected_reports.size() == 0) begin
                if (mismatches < 10)
                    $display("report %h arrived with no request outstanding", got);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("removed_priority", want.removed_priority, got.removed_priority);
            compare_field("removed_payload", want.removed_payload, got.removed_payload);
            compare_field("insert_position", want.insert_position, got.insert_position);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("front_priority", want.front_priority, got.front_priority);
            compare_field("front_payload", want.front_payload, got.front_payload);
            compare_field("tail_priority", want.tail_priority, got.tail_priority);
            compare_field("tail_payload", want.tail_payload, got.tail_payload);
            checked++;
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    sorted_queue_mirror mirror;
    int send_idle_pct = 31;
    int recv_idle_pct = 72;
    int long_hold     = 0;
    int requests_sent = 0;
    int cycle_count   = 0;

    sorted_priority_queue_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(input t_op op, input int pri, input logic [REC_BITS-1:0] pay);
        t_in_item req;
        req.op           = op;
        req.new_priority = PRI_BITS'(pri);
        req.new_payload  = pay;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        mirror.apply_request(req);
        requests_sent++;
    endtask

    task automatic send_random(input int count, input int insert_pct);
        int                  r;
        int                  pri;
        t_op                 op;
        logic [REC_BITS-1:0] pay;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < insert_pct) op = OP_INSERT;
            else if (r < 96) op = OP_REMOVE;
            else if (r < 98) op = OP_CLEAR;
            else op = OP_NOP;
            case ($urandom_range(9))
                0: pri = 32767;
                1: pri = -32768;
                2, 3, 4, 5: pri = int'($urandom_range(8)) - 4;
                default: pri = int'($urandom_range(65535)) - 32768;
            endcase
            case ($urandom_range(9))
                0: pay = '0;
                1: pay = '1;
                default: pay = $urandom;
            endcase
            send_request(op, pri, pay);
        end
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        while (mirror.expected_reports.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_ready && out_valid === 1'b1) mirror.check_report(out_data);
        if (long_hold > 0) begin
            out_ready <= 1'b0;
            long_hold--;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d reports outstanding",
                 cycle_count, mirror.expected_reports.size());
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        int phase;
        mirror = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corners, then fill with extremes and ties, then remove, nop and clear
        send_request(OP_REMOVE, 0, 32'h0);
        send_request(OP_CLEAR, 5, 32'h1);
        send_request(OP_NOP, -1, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 0, 32'h0000_0001);
        send_request(OP_INSERT, 32767, 32'hFFFF_FFFF);
        send_request(OP_INSERT, -32768, 32'h0000_0000);
        send_request(OP_INSERT, 0, 32'h0000_0004);
        send_request(OP_INSERT, -1, 32'h8000_0000);
        send_request(OP_INSERT, 1, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 32767, 32'h0000_0007);
        send_request(OP_INSERT, -32768, 32'h0000_0008);
        send_request(OP_INSERT, 100, 32'h5555_5555);
        send_request(OP_INSERT, -100, 32'hAAAA_AAAA);
        send_request(OP_INSERT, 5, 32'h0000_000B);
        send_request(OP_INSERT, 5, 32'h0000_000C);
        send_request(OP_INSERT, 5, 32'h0000_000D);
        send_request(OP_INSERT, 16384, 32'h0000_000E);
        send_request(OP_INSERT, -16384, 32'h0000_000F);
        send_request(OP_INSERT, 7, 32'h0000_0010);
        send_request(OP_INSERT, 3, 32'h0000_0011);
        send_request(OP_REMOVE, 0, 32'h0);
        send_request(OP_REMOVE, 0, 32'h0);
        send_request(OP_NOP, 0, 32'h0);
        send_request(OP_CLEAR, 0, 32'h0);
        drain_reports();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            send_random(60, 70);
            // long receiver stall so the request side backs up
            if (phase == 2) long_hold = 150;
            send_random(60, 35);
            send_random(50, 60);
            drain_reports();
        end

        repeat (12) @(posedge clk);
        $display("tb_top: %0d requests under three pacing mixes, %0d reports checked",
                 requests_sent, mirror.checked);
        $display("tb_top: %0d full and %0d empty reports seen, %0d mismatches",
                 mirror.full_seen, mirror.empty_seen, mirror.mismatches);
        if (mirror.mismatches == 0 && mirror.expected_reports.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
